// ===== rtl/core/vp8_coefficient_quantizer_defines.svh =====
// ---------------------------------------------------------------------------
// VP8 coefficient quantizer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef VP8_COEFFICIENT_QUANTIZER_DEFINES_SVH
`define VP8_COEFFICIENT_QUANTIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define VCQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vcq: invariant violated");
// Antecedent at one edge requires the consequent at the next edge.
`define VCQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcq: sequence check failed");
`else
`define VCQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define VCQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/vcq_pkg.sv =====
// ---------------------------------------------------------------------------
// VP8 coefficient quantizer package
// Widths, macroblock layout constants, register codes and cell payload type.
// ---------------------------------------------------------------------------
package vcq_pkg;

    localparam int COEF_W    = 16;
    localparam int STEP_W    = 9;
    localparam int POS_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // One division cell per quotient bit.
    localparam int DIV_STEPS = COEF_W;

    localparam logic [POS_W-1:0] MB_COEF_COUNT = POS_W'(16 + (16 * 16) + (4 * 16) + (4 * 16));
    localparam logic [POS_W-1:0] Y2_END        = POS_W'(16);
    localparam logic [POS_W-1:0] LUMA_END      = POS_W'(16 + (16 * 16));
    localparam logic [POS_W-1:0] LAST_POS      = MB_COEF_COUNT - POS_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_Y2_DC     = 3'd0,
        REG_Y2_AC     = 3'd1,
        REG_LUMA_DC   = 3'd2,
        REG_LUMA_AC   = 3'd3,
        REG_CHROMA_DC = 3'd4,
        REG_CHROMA_AC = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0] y2_dc;
        logic [STEP_W-1:0] y2_ac;
        logic [STEP_W-1:0] luma_dc;
        logic [STEP_W-1:0] luma_ac;
        logic [STEP_W-1:0] chroma_dc;
        logic [STEP_W-1:0] chroma_ac;
    } step_set_t;

    // Payload handed from cell to cell. work holds the not yet consumed
    // dividend bits in its upper part and the quotient bits in its lower part.
    typedef struct packed {
        logic              neg;
        logic              last;
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] rem;
        logic [COEF_W-1:0] work;
    } cell_data_t;

endpackage

// ===== rtl/core/vcq_prep.sv =====
// ---------------------------------------------------------------------------
// VP8 coefficient quantizer input stage
// Picks the step for the current position, takes the magnitude and adds the
// rounding offset; registers the seed for the division chain.
// ---------------------------------------------------------------------------
module vcq_prep
    import vcq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [COEF_W-1:0] coefficient,
    input  logic [POS_W-1:0]  position,
    input  step_set_t         steps,
    output logic              out_valid,
    output cell_data_t        out_data
);

    logic              valid_reg;
    logic              valid_next;
    cell_data_t        data_reg;
    cell_data_t        data_next;
    logic              is_dc;
    logic [STEP_W-1:0] raw_step;
    logic [STEP_W-1:0] step;
    logic [COEF_W-1:0] mag;

    always_comb
    begin
        is_dc = (position[3:0] == 4'd0);
        if (position < Y2_END)
        begin
            raw_step = is_dc ? steps.y2_dc : steps.y2_ac;
        end
        else if (position < LUMA_END)
        begin
            raw_step = is_dc ? steps.luma_dc : steps.luma_ac;
        end
        else
        begin
            raw_step = is_dc ? steps.chroma_dc : steps.chroma_ac;
        end
        // A zero step behaves as a step of one.
        step = (raw_step == '0) ? STEP_W'(1) : raw_step;

        // Most negative input maps to 0x8000, which is its true magnitude.
        mag = coefficient[COEF_W-1] ? (~coefficient + COEF_W'(1)) : coefficient;

        data_next.neg  = coefficient[COEF_W-1];
        data_next.last = (position == LAST_POS);
        data_next.step = step;
        data_next.rem  = '0;
        data_next.work = mag + COEF_W'(step[STEP_W-1:1]);

        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/vcq_div_cell.sv =====
// ---------------------------------------------------------------------------
// VP8 coefficient quantizer division cell
// One restoring division step: brings down one dividend bit, compares the
// partial remainder with the step and shifts in one quotient bit.
// ---------------------------------------------------------------------------
module vcq_div_cell
    import vcq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       in_valid,
    input  cell_data_t in_data,
    output logic       out_valid,
    output cell_data_t out_data
);

    logic              valid_reg;
    logic              valid_next;
    cell_data_t        data_reg;
    cell_data_t        data_next;
    logic [STEP_W:0]   trial;
    logic [STEP_W:0]   diff;
    logic              fits;

    always_comb
    begin
        trial = {in_data.rem, in_data.work[COEF_W-1]};
        diff  = trial - {1'b0, in_data.step};
        fits  = (trial >= {1'b0, in_data.step});

        data_next      = in_data;
        // Either way the new remainder stays below the step, so 9 bits hold it.
        data_next.rem  = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
        data_next.work = {in_data.work[COEF_W-2:0], fits};

        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/vp8_coefficient_quantizer.sv =====
// ---------------------------------------------------------------------------
// VP8 coefficient quantizer
// Divides each coefficient by the step of its macroblock position, rounding
// half away from zero, through a chain of one-bit division cells.
// ---------------------------------------------------------------------------
//  channel   direction  tdata / data                   side fields
//  s_axis    in         [15:0] coefficient             -
//  m_axis    out        [15:0] quantized               tlast = last_in_macroblock
//  cfg       in         cfg_data[8:0] step             cfg_index selects register
//
//  One coefficient per cycle sustained; the chain holds the input stage, 16
//  division cells (one per quotient bit) and the output register.
//  The whole chain advances only when the output register is empty or taken,
//  so a stalled output holds every stage in place.
//  Reset clears the position counter and loads the default steps.
// ---------------------------------------------------------------------------
`include "vp8_coefficient_quantizer_defines.svh"

module vp8_coefficient_quantizer
    import vcq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [COEF_W-1:0]    s_tdata,    // [15:0] coefficient
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [COEF_W-1:0]    m_tdata,    // [15:0] quantized
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    step_set_t         steps_reg;
    step_set_t         steps_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [COEF_W-1:0] m_tdata_reg;
    logic [COEF_W-1:0] m_tdata_next;
    logic              m_tlast_reg;
    logic              m_tlast_next;
    logic              advance;
    logic              in_fire;
    logic [STEP_W-1:0] cfg_step;

    logic              cell_valid [DIV_STEPS+1];
    cell_data_t        cell_data  [DIV_STEPS+1];

    assign advance   = !m_tvalid_reg || m_tready;
    assign s_tready  = advance;
    assign in_fire   = s_tvalid && advance;
    assign cfg_ready = 1'b1;
    assign cfg_step  = cfg_data[STEP_W-1:0];

    // Configuration writes; unknown indexes are dropped.
    always_comb
    begin
        steps_next = steps_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_Y2_DC:     steps_next.y2_dc     = cfg_step;
                REG_Y2_AC:     steps_next.y2_ac     = cfg_step;
                REG_LUMA_DC:   steps_next.luma_dc   = cfg_step;
                REG_LUMA_AC:   steps_next.luma_ac   = cfg_step;
                REG_CHROMA_DC: steps_next.chroma_dc = cfg_step;
                REG_CHROMA_AC: steps_next.chroma_ac = cfg_step;
                default:       steps_next           = steps_reg;
            endcase
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (in_fire)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + POS_W'(1);
        end
    end

    vcq_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (s_tvalid),
        .coefficient (s_tdata),
        .position    (pos_reg),
        .steps       (steps_reg),
        .out_valid   (cell_valid[0]),
        .out_data    (cell_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        vcq_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // Apply the sign to the finished quotient.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (advance)
        begin
            m_tvalid_next = cell_valid[DIV_STEPS];
            m_tdata_next  = cell_data[DIV_STEPS].neg ?
                            (~cell_data[DIV_STEPS].work + COEF_W'(1)) :
                            cell_data[DIV_STEPS].work;
            m_tlast_next  = cell_data[DIV_STEPS].last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg.y2_dc     <= STEP_W'(8);
            steps_reg.y2_ac     <= STEP_W'(8);
            steps_reg.luma_dc   <= STEP_W'(4);
            steps_reg.luma_ac   <= STEP_W'(4);
            steps_reg.chroma_dc <= STEP_W'(4);
            steps_reg.chroma_ac <= STEP_W'(4);
            pos_reg             <= '0;
            m_tvalid_reg        <= 1'b0;
        end
        else
        begin
            steps_reg    <= steps_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `VCQ_ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_reg <= LAST_POS)
    `VCQ_ASSERT_NEXT(a_pos_wrap, clk, rst_n, in_fire && (pos_reg == LAST_POS), pos_reg == '0)
    `VCQ_ASSERT_ALWAYS(a_rem_below_step, clk, rst_n,
        !cell_valid[DIV_STEPS] || (cell_data[DIV_STEPS].rem < cell_data[DIV_STEPS].step))

endmodule
